FILE: rtl/ros_pkg.sv
// ----------------------------------------------------------------------------
// ros_pkg
// shared constants, request codes and types of the roulette operator selector
// ----------------------------------------------------------------------------
package ros_pkg;

	localparam int NUM_ENTRIES = 16;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int W_W         = 17;
	localparam int FRAC_W      = 16;
	localparam int EIU_W       = 5;
	localparam int TOT_W       = IDX_W + W_W;
	localparam int PROD_W      = 2 * W_W;
	localparam int CFG_IDX_W   = 1;

	localparam logic [W_W-1:0]   ONE_Q16       = W_W'(65536);
	localparam logic [EIU_W-1:0] EIU_RESET     = EIU_W'(16);
	localparam logic [W_W-1:0]   INERTIA_RESET = W_W'(32768);

	// request codes
	localparam logic [1:0] REQ_SELECT = 2'd0;
	localparam logic [1:0] REQ_UPDATE = 2'd1;
	localparam logic [1:0] REQ_WRITE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INERTIA = 1'b1;

	typedef struct packed {
		logic [W_W-1:0] w;
		logic           m;
	} entry_t;

	typedef struct packed {
		logic             clear;
		logic             sum_en;
		logic             walk_en;
		logic             uniform;
		logic [IDX_W-1:0] step;
		logic [IDX_W-1:0] pick;
		logic [CNT_W-1:0] n;
		logic [TOT_W-1:0] pos;
	} head_ctrl_t;

	typedef struct packed {
		logic [TOT_W-1:0] acc_nxt;
		logic [IDX_W-1:0] chosen;
		logic [W_W-1:0]   wout;
	} head_stat_t;

endpackage

FILE: rtl/ros_req_if.sv
// ----------------------------------------------------------------------------
// ros_req_if
// request channel: valid/ready handshake with one request per transaction
// ----------------------------------------------------------------------------
interface ros_req_if;
	import ros_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [IDX_W-1:0]      entry_index;
	logic [W_W-1:0]        write_weight;
	logic                  write_selectable;
	logic [FRAC_W-1:0]     random_fraction;
	logic                  good_seen;
	logic                  normal_seen;
	logic                  bad_seen;

	modport source (
		output valid, req_type, entry_index, write_weight, write_selectable,
		       random_fraction, good_seen, normal_seen, bad_seen,
		input  ready
	);

	modport sink (
		input  valid, req_type, entry_index, write_weight, write_selectable,
		       random_fraction, good_seen, normal_seen, bad_seen,
		output ready
	);
endinterface

FILE: rtl/ros_rsp_if.sv
// ----------------------------------------------------------------------------
// ros_rsp_if
// response channel: valid/ready handshake with one result per transaction
// ----------------------------------------------------------------------------
interface ros_rsp_if;
	import ros_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] chosen_index;
	logic             used_uniform;
	logic [W_W-1:0]   weight_out;
	logic             index_error;

	modport source (
		output valid, chosen_index, used_uniform, weight_out, index_error,
		input  ready
	);

	modport sink (
		input  valid, chosen_index, used_uniform, weight_out, index_error,
		output ready
	);
endinterface

FILE: rtl/roulette_operator_selector_core.sv
// ----------------------------------------------------------------------------
// roulette_operator_selector_core
// select: a summing walk of the chain after entries_in_use was written, then fraction
//   scaling, a 16-step walk of the chain and the output load
// update: read, inertia product, blend and write back; write: read and write back;
//   bad index or unknown request: straight to the output load; one request at a time
// the next request is taken the cycle after a result is loaded; the walk sets the rate
// reset: weights zero, all marks selectable, registers at reset values, no sweep
// ----------------------------------------------------------------------------
module roulette_operator_selector_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ros_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ros_pkg::W_W-1:0]         cfg_wdata,
	ros_req_if.sink                         req,
	ros_rsp_if.source                       rsp
);
	import ros_pkg::*;

	// sequencer states
	localparam int         ST_W     = 3;
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SUM   = 3'd1;  // walk the chain to rebuild the total
	localparam logic [2:0] ST_MUL   = 3'd2;  // scale the random fraction
	localparam logic [2:0] ST_WALK  = 3'd3;  // walk the chain, running sum picks
	localparam logic [2:0] ST_UPD1  = 3'd4;  // read the addressed entry
	localparam logic [2:0] ST_UPD2  = 3'd5;  // inertia product
	localparam logic [2:0] ST_UPD3  = 3'd6;  // blend and write back
	localparam logic [2:0] ST_DONE  = 3'd7;  // hand result to output register

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_ENTRIES - 1);

	logic [ST_W-1:0]      state_q;
	logic [IDX_W-1:0]     k_q;

	// configuration
	logic [EIU_W-1:0]     eiu_q;
	logic [W_W-1:0]       inertia_q;
	logic [CNT_W-1:0]     n_eff;
	logic [W_W-1:0]       g_eff;

	// kept total of selectable weights among the active entries
	logic [TOT_W-1:0]     total_q;
	logic                 total_ok_q;

	// latched request
	logic [1:0]           type_q;
	logic [IDX_W-1:0]     idx_q;
	logic [W_W-1:0]       wval_q;
	logic                 wsel_q;
	logic [FRAC_W-1:0]    frac_q;
	logic                 good_q;
	logic                 normal_q;
	logic                 bad_q;
	logic                 err_q;

	// select working registers
	logic [TOT_W-1:0]     pos_q;
	logic [IDX_W-1:0]     pick_q;
	logic                 uniform_q;

	// update working registers
	entry_t               rd_q;
	logic [PROD_W-1:0]    prod_q;
	logic [W_W-1:0]       res_w_q;

	// output register
	logic                 out_valid_q;
	logic [IDX_W-1:0]     out_chosen_q;
	logic                 out_uniform_q;
	logic [W_W-1:0]       out_w_q;
	logic                 out_err_q;

	logic                 accept;
	logic                 acc_err;
	logic                 out_load;
	logic [W_W-1:0]       wval_sat;
	logic [FRAC_W+CNT_W-1:0] pick_prod;
	logic [FRAC_W+TOT_W-1:0] pos_prod;
	logic [W_W:0]         prod_hi;
	logic [W_W:0]         blend;
	entry_t               new_entry;

	// cell chain
	entry_t               cell_cur [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] cell_load;
	logic                 chain_shift;
	head_ctrl_t           hctrl;
	head_stat_t           hstat;

	// ------------------------------------------------------------------------
	// effective configuration values
	// ------------------------------------------------------------------------
	always_comb begin
		if (eiu_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(eiu_q) > 32'(NUM_ENTRIES)) begin
			n_eff = CNT_W'(NUM_ENTRIES);
		end else begin
			n_eff = CNT_W'(eiu_q);
		end
		g_eff = (inertia_q > ONE_Q16) ? ONE_Q16 : inertia_q;
	end

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign acc_err   = ((req.req_type == REQ_UPDATE) || (req.req_type == REQ_WRITE)) &&
	                   (CNT_W'(req.entry_index) >= n_eff);
	assign wval_sat  = (req.write_weight > ONE_Q16) ? ONE_Q16 : req.write_weight;

	// ------------------------------------------------------------------------
	// scaled fraction: uniform pick and wheel position
	// ------------------------------------------------------------------------
	assign pick_prod = (FRAC_W+CNT_W)'(frac_q) * (FRAC_W+CNT_W)'(n_eff);
	assign pos_prod  = (FRAC_W+TOT_W)'(frac_q) * (FRAC_W+TOT_W)'(total_q);

	// ------------------------------------------------------------------------
	// blend toward aim: aim of one is (g*w)>>16 + (1-g) exactly, aim of zero
	// is (g*w)>>16, aim equal to w leaves w unchanged
	// ------------------------------------------------------------------------
	always_comb begin
		prod_hi = prod_q[PROD_W-1:FRAC_W];
		if (good_q) begin
			blend = prod_hi + (W_W+1)'(ONE_Q16 - g_eff);
		end else if (normal_q) begin
			blend = (W_W+1)'(rd_q.w);
		end else if (bad_q) begin
			blend = prod_hi;
		end else begin
			blend = (W_W+1)'(rd_q.w);
		end
		if (type_q == REQ_WRITE) begin
			new_entry.w = wval_q;
			new_entry.m = wsel_q;
		end else begin
			new_entry.w = (blend > (W_W+1)'(ONE_Q16)) ? ONE_Q16 : blend[W_W-1:0];
			new_entry.m = rd_q.m;
		end
	end

	// ------------------------------------------------------------------------
	// cell chain: rotates one place toward the head in each walk cycle, so
	// entry k sits at the head on walk step k and all return home after a walk
	// ------------------------------------------------------------------------
	assign chain_shift = (state_q == ST_SUM) || (state_q == ST_WALK);

	for (genvar j = 0; j < NUM_ENTRIES; j++) begin : g_cell
		assign cell_load[j] = (state_q == ST_UPD3) && (idx_q == IDX_W'(j));

		ros_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (chain_shift),
			.load   (cell_load[j]),
			.nxt    (cell_cur[(j + 1) % NUM_ENTRIES]),
			.ld     (new_entry),
			.cur    (cell_cur[j])
		);
	end

	always_comb begin
		hctrl.clear   = (state_q == ST_IDLE) || (state_q == ST_MUL);
		hctrl.sum_en  = (state_q == ST_SUM);
		hctrl.walk_en = (state_q == ST_WALK);
		hctrl.uniform = uniform_q;
		hctrl.step    = k_q;
		hctrl.pick    = pick_q;
		hctrl.n       = n_eff;
		hctrl.pos     = pos_q;
	end

	ros_head u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hctrl),
		.head   (cell_cur[0]),
		.stat   (hstat)
	);

	// ------------------------------------------------------------------------
	// sequencer, kept total and configuration registers
	// ------------------------------------------------------------------------
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			total_q    <= '0;
			total_ok_q <= 1'b1;
			eiu_q      <= EIU_RESET;
			inertia_q  <= INERTIA_RESET;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (accept) begin
						if (req.req_type == REQ_SELECT) begin
							state_q <= total_ok_q ? ST_MUL : ST_SUM;
						end else if (((req.req_type == REQ_UPDATE) ||
						              (req.req_type == REQ_WRITE)) && !acc_err) begin
							state_q <= ST_UPD1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SUM: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_STEP) begin
						total_q    <= hstat.acc_nxt;
						total_ok_q <= 1'b1;
						k_q        <= '0;
						state_q    <= ST_MUL;
					end
				end
				ST_MUL: begin
					k_q     <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_STEP) begin
						k_q     <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_UPD1: begin
					state_q <= (type_q == REQ_UPDATE) ? ST_UPD2 : ST_UPD3;
				end
				ST_UPD2: begin
					state_q <= ST_UPD3;
				end
				ST_UPD3: begin
					// swap the old contribution for the new one
					total_q <= total_q - (rd_q.m ? TOT_W'(rd_q.w) : '0)
					                   + (new_entry.m ? TOT_W'(new_entry.w) : '0);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration writes are to arrive only while idle; the block does not enforce this
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENTRIES: begin
						eiu_q      <= cfg_wdata[EIU_W-1:0];
						total_ok_q <= 1'b0;
					end
					CFG_INERTIA: begin
						inertia_q <= cfg_wdata;
					end
					default: begin
						inertia_q <= inertia_q;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// request and working payload registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q   <= req.req_type;
			idx_q    <= req.entry_index;
			wval_q   <= wval_sat;
			wsel_q   <= req.write_selectable;
			frac_q   <= req.random_fraction;
			good_q   <= req.good_seen;
			normal_q <= req.normal_seen;
			bad_q    <= req.bad_seen;
			err_q    <= acc_err;
		end
		if (state_q == ST_MUL) begin
			pos_q     <= pos_prod[FRAC_W +: TOT_W];
			pick_q    <= pick_prod[FRAC_W +: IDX_W];
			uniform_q <= (total_q == '0);
		end
		if (state_q == ST_UPD1) begin
			rd_q <= cell_cur[idx_q];
		end
		if (state_q == ST_UPD2) begin
			prod_q <= PROD_W'(g_eff) * PROD_W'(rd_q.w);
		end
		if (state_q == ST_UPD3) begin
			res_w_q <= new_entry.w;
		end
	end

	// ------------------------------------------------------------------------
	// output register: holds a finished result while the next request is taken
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (type_q == REQ_SELECT) begin
				out_chosen_q  <= hstat.chosen;
				out_uniform_q <= uniform_q;
				out_w_q       <= hstat.wout;
				out_err_q     <= 1'b0;
			end else if (((type_q == REQ_UPDATE) || (type_q == REQ_WRITE)) && !err_q) begin
				out_chosen_q  <= idx_q;
				out_uniform_q <= 1'b0;
				out_w_q       <= res_w_q;
				out_err_q     <= 1'b0;
			end else begin
				// bad index or unknown request: nothing changed, index echoed
				out_chosen_q  <= idx_q;
				out_uniform_q <= 1'b0;
				out_w_q       <= '0;
				out_err_q     <= err_q;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.chosen_index = out_chosen_q;
	assign rsp.used_uniform = out_uniform_q;
	assign rsp.weight_out   = out_w_q;
	assign rsp.index_error  = out_err_q;
endmodule

FILE: rtl/ros_cell.sv
// ----------------------------------------------------------------------------
// ros_cell
// one table entry: weight and selectable mark, rotates to its neighbor on shift
// ----------------------------------------------------------------------------
module ros_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  logic            load,
	input  ros_pkg::entry_t nxt,
	input  ros_pkg::entry_t ld,
	output ros_pkg::entry_t cur
);
	import ros_pkg::*;

	entry_t cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.w <= '0;
			cur_q.m <= 1'b1;
		end else if (load) begin
			cur_q <= ld;
		end else if (shift) begin
			cur_q <= nxt;
		end
	end

	assign cur = cur_q;
endmodule

FILE: rtl/ros_head.sv
// ----------------------------------------------------------------------------
// ros_head
// sits at the head of the cell chain: running sum and pick of the walked entry
// ----------------------------------------------------------------------------
module ros_head (
	input  logic                clk,
	input  logic                arst_n,
	input  ros_pkg::head_ctrl_t ctrl,
	input  ros_pkg::entry_t     head,
	output ros_pkg::head_stat_t stat
);
	import ros_pkg::*;

	logic [TOT_W-1:0] acc_q;
	logic [TOT_W-1:0] acc_nxt;
	logic             found_q;
	logic [IDX_W-1:0] chosen_q;
	logic [W_W-1:0]   wout_q;
	logic             part;
	logic             hit;

	always_comb begin
		// entry takes part when inside the active range and selectable
		part    = (CNT_W'(ctrl.step) < ctrl.n) && head.m;
		acc_nxt = acc_q + (part ? TOT_W'(head.w) : '0);
		if (ctrl.uniform) begin
			hit = (ctrl.step == ctrl.pick);
		end else begin
			hit = part && (acc_nxt >= ctrl.pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			found_q  <= 1'b0;
			chosen_q <= '0;
			wout_q   <= '0;
		end else if (ctrl.clear) begin
			acc_q    <= '0;
			found_q  <= 1'b0;
			chosen_q <= '0;
			wout_q   <= '0;
		end else if (ctrl.sum_en) begin
			acc_q <= acc_nxt;
		end else if (ctrl.walk_en) begin
			acc_q <= acc_nxt;
			if (hit && !found_q) begin
				found_q  <= 1'b1;
				chosen_q <= ctrl.step;
				wout_q   <= head.w;
			end
		end
	end

	assign stat.acc_nxt = acc_nxt;
	assign stat.chosen  = chosen_q;
	assign stat.wout    = wout_q;
endmodule

FILE: tb/tb_roulette_operator_selector_core.sv
// ----------------------------------------------------------------------------
// tb_roulette_operator_selector_core
// self-checking bench for the roulette operator selector: directed requests
// at the field and register extremes, then randomized phases of select,
// update and write traffic under sender bursts and receiver stalls; each
// response is compared field by field with an in-bench model of the table
// ----------------------------------------------------------------------------
module tb_roulette_operator_selector_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ros_pkg::*;

	// request code that the block must ignore
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// weight mixes used by the random phases
	localparam int STYLE_MIXED  = 0;
	localparam int STYLE_SPARSE = 1;
	localparam int STYLE_TINY   = 2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [IDX_W-1:0]  index;
		logic [W_W-1:0]    wval;
		logic              wsel;
		logic [FRAC_W-1:0] frac;
		logic              good;
		logic              normal;
		logic              bad;
	} ros_request_t;

	typedef struct packed {
		logic [IDX_W-1:0] chosen;
		logic             uniform;
		logic [W_W-1:0]   weight;
		logic             err;
	} ros_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [W_W-1:0]       cfg_wdata;

	ros_req_if req_if ();
	ros_rsp_if rsp_if ();

	roulette_operator_selector_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// in-bench copy of the wheel: weights, marks and both registers
	logic [W_W-1:0]   wheel_weight [NUM_ENTRIES];
	logic             wheel_mark   [NUM_ENTRIES];
	logic [EIU_W-1:0] entries_setting;
	logic [W_W-1:0]   inertia_setting;

	// predicted responses, oldest first
	ros_result_t pending_results [$];

	int unsigned error_count       = 0;
	int unsigned checked_count     = 0;
	int unsigned select_count      = 0;
	int unsigned uniform_count     = 0;
	int unsigned update_count      = 0;
	int unsigned write_count       = 0;
	int unsigned index_error_count = 0;
	int unsigned unknown_count     = 0;
	int unsigned setting_count     = 0;

	// sender pacing: steady means back-to-back requests, else bursts and gaps
	bit          sender_steady = 1'b0;
	int unsigned burst_left    = 0;
	int          weight_style  = STYLE_MIXED;

	// effective entry count after clamping the register to 1..NUM_ENTRIES
	function automatic int unsigned entries_active();
		if (entries_setting == 0)
			return 1;
		if (entries_setting > NUM_ENTRIES)
			return NUM_ENTRIES;
		return entries_setting;
	endfunction

	// apply one accepted request to the wheel copy and return its response
	function automatic ros_result_t predict_outcome(ros_request_t r);
		ros_result_t     res;
		int unsigned     n;
		int unsigned     pick;
		longint unsigned total;
		longint unsigned pos;
		longint unsigned run;
		longint unsigned g;
		longint unsigned w;
		longint unsigned aim;
		longint unsigned blend;
		bit              found;
		res        = '0;
		res.chosen = r.index;
		n          = entries_active();
		case (r.kind)
			REQ_SELECT: begin
				select_count++;
				total = 0;
				for (int i = 0; i < n; i++)
					if (wheel_mark[i])
						total += wheel_weight[i];
				if (total == 0) begin
					// nothing to spin on: uniform pick over entries in use, marks ignored
					pick = 32'((longint'(r.frac) * n) >> 16);
					if (pick >= n)
						pick = n - 1;
					res.chosen  = pick[IDX_W-1:0];
					res.uniform = 1'b1;
					res.weight  = wheel_weight[pick];
					uniform_count++;
				end else begin
					// first selectable entry whose running sum reaches the position; when the
					// position is zero the first selectable entry wins, even with zero weight
					pos   = (longint'(r.frac) * total) >> 16;
					run   = 0;
					found = 1'b0;
					for (int i = 0; i < n; i++) begin
						if (!found && wheel_mark[i]) begin
							run += wheel_weight[i];
							if (run >= pos) begin
								res.chosen = i[IDX_W-1:0];
								res.weight = wheel_weight[i];
								found      = 1'b1;
							end
						end
					end
				end
			end
			REQ_UPDATE, REQ_WRITE: begin
				if (r.index >= n) begin
					// out-of-range entry: nothing changes
					res.err = 1'b1;
					index_error_count++;
				end else if (r.kind == REQ_UPDATE) begin
					update_count++;
					g = (inertia_setting > ONE_Q16) ? ONE_Q16 : inertia_setting;
					w = wheel_weight[r.index];
					// good beats normal beats bad; no flag keeps the weight
					if (r.good)
						aim = ONE_Q16;
					else if (r.normal)
						aim = w;
					else if (r.bad)
						aim = 0;
					else
						aim = w;
					blend = (g * w + (ONE_Q16 - g) * aim) >> 16;
					if (blend > ONE_Q16)
						blend = ONE_Q16;
					wheel_weight[r.index] = blend[W_W-1:0];
					res.weight            = blend[W_W-1:0];
				end else begin
					write_count++;
					// weights above 1.0 are stored as 1.0
					wheel_weight[r.index] = (r.wval > ONE_Q16) ? ONE_Q16 : r.wval;
					wheel_mark[r.index]   = r.wsel;
					res.weight            = wheel_weight[r.index];
				end
			end
			default: begin
				// unknown request: only the index is echoed
				unknown_count++;
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		error_count++;
		$display("[%0t] mismatch on response %0d, %s: got %0d, expected %0d",
			$realtime, checked_count, what, got, want);
	endtask

	// drive one request and wait for its transaction; the expectation is
	// queued at the accepting edge, before any response can be seen
	task automatic send_request(input ros_request_t r);
		int unsigned gap;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 7);
				burst_left = $urandom_range(1, 24);
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left--;
		end
		req_if.req_type         <= r.kind;
		req_if.entry_index      <= r.index;
		req_if.write_weight     <= r.wval;
		req_if.write_selectable <= r.wsel;
		req_if.random_fraction  <= r.frac;
		req_if.good_seen        <= r.good;
		req_if.normal_seen      <= r.normal;
		req_if.bad_seen         <= r.bad;
		req_if.valid            <= 1'b1;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		pending_results.push_back(predict_outcome(r));
	endtask

	// directed request; flags are {good, normal, bad}
	task automatic issue(input logic [1:0] kind, input logic [IDX_W-1:0] index,
			input logic [W_W-1:0] wval, input logic wsel, input logic [FRAC_W-1:0] frac,
			input logic [2:0] flags);
		ros_request_t r;
		r.kind   = kind;
		r.index  = index;
		r.wval   = wval;
		r.wsel   = wsel;
		r.frac   = frac;
		r.good   = flags[2];
		r.normal = flags[1];
		r.bad    = flags[0];
		send_request(r);
	endtask

	// stop sending and wait until every predicted response has come back
	task automatic drain_pending();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes happen only with the block idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [W_W-1:0] value);
		drain_pending();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == CFG_ENTRIES)
			entries_setting = value[EIU_W-1:0];
		else
			inertia_setting = value;
		setting_count++;
		@(posedge clk);
	endtask

	function automatic ros_request_t random_request();
		ros_request_t r;
		int unsigned  roll;
		int unsigned  n;
		n    = entries_active();
		r    = '0;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			r.kind = REQ_SELECT;
		else if (roll < 65)
			r.kind = REQ_UPDATE;
		else if (roll < 96)
			r.kind = REQ_WRITE;
		else
			r.kind = REQ_UNKNOWN;
		// mostly legal entries, some beyond entries_in_use
		if ($urandom_range(0, 99) < 85)
			r.index = IDX_W'($urandom_range(0, n - 1));
		else
			r.index = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
		case (weight_style)
			STYLE_MIXED: begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					r.wval = '0;
				else if (roll == 1)
					r.wval = ONE_Q16;
				else if (roll < 5)
					r.wval = W_W'($urandom_range(0, (1 << W_W) - 1));
				else
					r.wval = W_W'($urandom_range(0, 65535));
				r.wsel = ($urandom_range(0, 3) != 0);
			end
			STYLE_SPARSE: begin
				// mostly zero or masked weights, so the uniform pick shows up often
				r.wval = ($urandom_range(0, 3) == 0) ? W_W'($urandom_range(0, 65536)) : '0;
				r.wsel = 1'($urandom_range(0, 1));
			end
			default: begin
				// tiny weights put the position right on running-sum boundaries
				r.wval = W_W'($urandom_range(0, 3));
				r.wsel = ($urandom_range(0, 7) != 0);
			end
		endcase
		roll = $urandom_range(0, 9);
		if (roll == 0)
			r.frac = '0;
		else if (roll == 1)
			r.frac = '1;
		else
			r.frac = FRAC_W'($urandom_range(0, 65535));
		{r.good, r.normal, r.bad} = 3'($urandom_range(0, 7));
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------------

	// all weights zero after reset: selects fall back to the uniform pick
	task automatic test_reset_state();
		issue(REQ_SELECT,  4'd0,  '0,        1'b0, 16'h0000, 3'b000);
		issue(REQ_SELECT,  4'd0,  '0,        1'b0, 16'hffff, 3'b000);
		issue(REQ_SELECT,  4'd9,  '0,        1'b0, 16'h8000, 3'b000);
		issue(REQ_UNKNOWN, 4'd15, 17'h1ffff, 1'b1, 16'hffff, 3'b111);
	endtask

	// writes at the weight extremes, an over-range weight, a masked entry
	task automatic test_table_writes();
		issue(REQ_WRITE,  4'd0,  ONE_Q16,   1'b1, 16'h0000, 3'b000);
		issue(REQ_WRITE,  4'd15, 17'h1ffff, 1'b1, 16'h0000, 3'b000);
		issue(REQ_WRITE,  4'd7,  '0,        1'b1, 16'h0000, 3'b000);
		issue(REQ_WRITE,  4'd3,  17'd12345, 1'b0, 16'h0000, 3'b000);
		issue(REQ_SELECT, 4'd0,  '0,        1'b0, 16'h0000, 3'b000);
		issue(REQ_SELECT, 4'd0,  '0,        1'b0, 16'hffff, 3'b000);
	endtask

	// outcome flag priority at the reset inertia
	task automatic test_outcome_updates();
		issue(REQ_UPDATE, 4'd0, '0, 1'b0, 16'h0000, 3'b000);
		issue(REQ_UPDATE, 4'd0, '0, 1'b0, 16'h0000, 3'b001);
		issue(REQ_UPDATE, 4'd0, '0, 1'b0, 16'h0000, 3'b010);
		issue(REQ_UPDATE, 4'd0, '0, 1'b0, 16'h0000, 3'b011);
		issue(REQ_UPDATE, 4'd0, '0, 1'b0, 16'h0000, 3'b101);
		issue(REQ_UPDATE, 4'd3, '0, 1'b0, 16'h0000, 3'b111);
	endtask

	// entry count of zero and above range, inertia at zero, one and above one
	task automatic test_register_extremes();
		write_register(CFG_ENTRIES, W_W'(0));
		issue(REQ_WRITE,  4'd1,  17'd500, 1'b1, 16'h0000, 3'b000);
		issue(REQ_UPDATE, 4'd15, '0,      1'b0, 16'h0000, 3'b100);
		issue(REQ_SELECT, 4'd0,  '0,      1'b0, 16'hffff, 3'b000);
		write_register(CFG_ENTRIES, W_W'(31));
		write_register(CFG_INERTIA, W_W'(0));
		issue(REQ_UPDATE, 4'd15, '0,      1'b0, 16'h0000, 3'b001);
		issue(REQ_UPDATE, 4'd15, '0,      1'b0, 16'h0000, 3'b100);
		write_register(CFG_INERTIA, 17'h1ffff);
		issue(REQ_UPDATE, 4'd0,  '0,      1'b0, 16'h0000, 3'b001);
		write_register(CFG_ENTRIES, W_W'(1));
		write_register(CFG_INERTIA, ONE_Q16);
		issue(REQ_WRITE,  4'd0,  '0,      1'b1, 16'h0000, 3'b000);
		issue(REQ_SELECT, 4'd0,  '0,      1'b0, 16'hffff, 3'b000);
	endtask

	// ------------------------------------------------------------------------
	// random traffic
	// ------------------------------------------------------------------------

	task automatic run_random_phase(input logic [EIU_W-1:0] entries,
			input logic [W_W-1:0] inertia, input bit steady, input int style,
			input int unsigned count);
		write_register(CFG_ENTRIES, W_W'(entries));
		write_register(CFG_INERTIA, inertia);
		sender_steady = steady;
		weight_style  = style;
		repeat (count)
			send_request(random_request());
		sender_steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(5'd16, 17'd32768, 1'b1, STYLE_MIXED, 100);
		run_random_phase(5'd1, 17'd0, 1'b0, STYLE_MIXED, 100);
		run_random_phase(5'd16, ONE_Q16, 1'b0, STYLE_SPARSE, 100);
		run_random_phase(5'd5, W_W'($urandom), 1'b0, STYLE_TINY, 100);
		run_random_phase(5'd0, 17'h1ffff, 1'b0, STYLE_MIXED, 100);
		run_random_phase(5'd31, W_W'($urandom), 1'b1, STYLE_SPARSE, 100);
		run_random_phase(5'($urandom_range(1, 16)), W_W'($urandom), 1'b0, STYLE_MIXED, 100);
		run_random_phase(5'($urandom_range(0, 31)), 17'd1, 1'b0, STYLE_TINY, 100);
		run_random_phase(5'($urandom_range(0, 31)), 17'd65535, 1'b0, STYLE_MIXED, 100);
		run_random_phase(5'd16, W_W'($urandom), 1'b0, STYLE_SPARSE, 100);
		run_random_phase(5'($urandom_range(2, 16)), W_W'($urandom), 1'b1, STYLE_MIXED, 100);
	endtask

	// ------------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------------

	// receiver backpressure: the pattern changes with tick[8:6], from
	// always ready through random and periodic stalls to long stalls
	initial begin : response_sink
		int unsigned tick;
		tick = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			case (tick[8:6])
				3'd0, 3'd1: rsp_if.ready <= 1'b1;
				3'd2:       rsp_if.ready <= 1'($urandom_range(0, 1));
				3'd3:       rsp_if.ready <= (tick[1:0] == 2'b00);
				3'd4:       rsp_if.ready <= (tick[4:0] >= 5'd18);
				3'd5:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
				3'd6:       rsp_if.ready <= tick[2];
				default:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// every response transaction is matched against the oldest prediction
	initial begin : response_check
		ros_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				checked_count++;
				if (pending_results.size() == 0) begin
					report_mismatch("response with nothing pending", rsp_if.chosen_index, 0);
				end else begin
					want = pending_results.pop_front();
					if (rsp_if.chosen_index !== want.chosen)
						report_mismatch("chosen_index", rsp_if.chosen_index, want.chosen);
					if (rsp_if.used_uniform !== want.uniform)
						report_mismatch("used_uniform", rsp_if.used_uniform, want.uniform);
					if (rsp_if.weight_out !== want.weight)
						report_mismatch("weight_out", rsp_if.weight_out, want.weight);
					if (rsp_if.index_error !== want.err)
						report_mismatch("index_error", rsp_if.index_error, want.err);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= CFG_ENTRIES;
		cfg_wdata               <= '0;
		req_if.valid            <= 1'b0;
		req_if.req_type         <= REQ_SELECT;
		req_if.entry_index      <= '0;
		req_if.write_weight     <= '0;
		req_if.write_selectable <= 1'b0;
		req_if.random_fraction  <= '0;
		req_if.good_seen        <= 1'b0;
		req_if.normal_seen      <= 1'b0;
		req_if.bad_seen         <= 1'b0;

		// model at its reset state: zero weights, all selectable
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			wheel_weight[i] = '0;
			wheel_mark[i]   = 1'b1;
		end
		entries_setting = EIU_RESET;
		inertia_setting = INERTIA_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_table_writes();
		test_outcome_updates();
		test_register_extremes();
		test_random_traffic();

		// let the last responses come home, then a margin for stray ones
		drain_pending();
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("responses never returned", 0, pending_results.size());

		$display("covered %0d responses: %0d selects (%0d uniform), %0d updates, %0d writes",
			checked_count, select_count, uniform_count, update_count, write_count);
		$display("plus %0d index errors and %0d unknown requests over %0d register writes",
			index_error_count, unknown_count, setting_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#2500000;
		$display("timeout with %0d responses still pending", pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
